[src/ccrle_pkg.sv]
// Package for the character-code run-length encoder.
// Holds shared types, result kind codes and the character code table.
// No dependencies.
`timescale 1ns / 1ps

package ccrle_pkg;

   localparam int CodeWidth  = 7;
   localparam int ValueWidth = 8;
   localparam int LenWidth   = 8;

   typedef enum logic [1:0] {
      KIND_CODE   = 2'd0,
      KIND_MARKER = 2'd1,
      KIND_COUNT  = 2'd2
   } kind_type;

   // CSR indexes
   localparam logic CSR_MARKER_VALUE = 1'b0;
   localparam logic CSR_COPY_LIMIT   = 1'b1;

   // One run to be sent out
   typedef struct packed {
      logic                 vld;
      logic [CodeWidth-1:0] code;
      logic [LenWidth-1:0]  len;
      logic                 esc;
   } job_type;

   // Work caused by one input item: the closed old run, then the end-of-string run
   typedef struct packed {
      job_type a;
      job_type b;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   function automatic logic [CodeWidth-1:0] code_of(input logic [7:0] b);
      logic [CodeWidth-1:0] c;
      c = '0;
      case (b)
         8'd33:   c = 7'd116;
         8'd34:   c = 7'd118;
         8'd35:   c = 7'd104;
         8'd36:   c = 7'd103;
         8'd37:   c = 7'd111;
         8'd38:   c = 7'd113;
         8'd39:   c = 7'd99;
         8'd48:   c = 7'd117;
         8'd64:   c = 7'd110;
         8'd65:   c = 7'd123;
         8'd80:   c = 7'd119;
         8'd100:  c = 7'd120;
         8'd101:  c = 7'd2;
         8'd102:  c = 7'd122;
         8'd103:  c = 7'd124;
         8'd116:  c = 7'd121;
         default: begin
            if (b inside {[8'd40:8'd63], [8'd66:8'd90]}) begin
               c = 7'(b - 8'd32);
            end else if (b inside {[8'd95:8'd99], [8'd104:8'd122]}) begin
               c = 7'(b - 8'd36);
            end else begin
               c = '0;
            end
         end
      endcase
      return c;
   endfunction

endpackage

[src/ccrle_if.sv]
// Handshake channel interfaces for the encoder: character input and result output.
// No dependencies; the field widths are written out as literals.
`timescale 1ns / 1ps

interface ccrle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_string;

   modport source (output valid, output char_byte, output end_of_string, input ready);
   modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

interface ccrle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] value;
   logic [1:0] kind;
   logic       last_of_burst;

   modport source (output valid, output value, output kind, output last_of_burst,
                   input ready);
   modport sink   (input valid, input value, input kind, input last_of_burst,
                   output ready);
endinterface

[src/char_code_run_length_encoder.sv]
// Top level of the character-code run-length encoder with escape marker.
// Depends on ccrle_pkg, ccrle_if, ccrle_front, ccrle_queue and ccrle_back.
//
// Usage:
//  - req channel: one character byte per transfer, end_of_string on the last
//    character of a string flushes the open run.
//  - rsp channel: result transfers (code, marker or run count), with
//    last_of_burst on the final result caused by one input item.
//  - csr port: csr_wr_en/csr_index/csr_wr_data; index 0 is marker_value,
//    index 1 is copy_limit. Write only while the block is idle.
//  - Path: job queue, back-end job register, then output register.
//  - Throughput: the front accepts one item per cycle while the job queue
//    has room; each item produces 0 to 4 results and the back end sends one
//    result per cycle while rsp is ready, so the rsp port sets the
//    sustained rate.
//  - Receiver stall: rsp holds its result; the queue fills up to QUEUE_DEPTH
//    items with output, then req.ready drops, also for items that only
//    extend a run.
//  - Reset: run state clears, queue empties, registers return to
//    marker 126 and copy limit 3.
`timescale 1ns / 1ps

module char_code_run_length_encoder #(
   parameter int MAX_RUN     = 255,  // 4..255
   parameter int QUEUE_DEPTH = 4     // 2 or more
) (
   input  logic       clock,
   input  logic       reset,
   ccrle_req_if.sink  req,
   ccrle_rsp_if.source rsp,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wr_data
);
   import ccrle_pkg::*;

   logic [7:0] marker_value_ff;
   logic [1:0] copy_limit_ff;

   logic         push;
   entry_type    push_entry;
   logic         pop;
   entry_type    head;
   q_status_type q_status;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         marker_value_ff <= 8'd126;
         copy_limit_ff   <= 2'd3;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MARKER_VALUE: marker_value_ff <= csr_wr_data;
            CSR_COPY_LIMIT:   copy_limit_ff   <= csr_wr_data[1:0];
            default:          marker_value_ff <= marker_value_ff;
         endcase
      end
   end

   // front: classify and track runs
   ccrle_front #(
      .MAX_RUN (MAX_RUN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .copy_limit (copy_limit_ff),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // job queue decouples the two sides
   ccrle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // back: expand jobs into result transfers
   ccrle_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_status     (q_status),
      .pop          (pop),
      .marker_value (marker_value_ff),
      .rsp          (rsp)
   );

endmodule

[src/ccrle_front.sv]
// Front end: maps characters to codes, tracks the open run, emits flush jobs.
// Depends on ccrle_pkg and ccrle_req_if.
`timescale 1ns / 1ps

module ccrle_front #(
   parameter int MAX_RUN = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   ccrle_req_if.sink              req,
   input  logic [1:0]             copy_limit,
   input  ccrle_pkg::q_status_type q_status,
   output logic                   push,
   output ccrle_pkg::entry_type   push_entry
);
   import ccrle_pkg::*;

   logic [CodeWidth-1:0] held_code_ff, held_code_in;
   logic [LenWidth-1:0]  run_len_ff, run_len_in;
   logic                 run_open_ff, run_open_in;

   logic [CodeWidth-1:0] code;
   logic [LenWidth-1:0]  lim;
   logic                 extend;
   logic [CodeWidth-1:0] new_code;
   logic [LenWidth-1:0]  new_len;
   logic                 take;

   assign req.ready = !q_status.full;
   assign take      = req.valid && req.ready;

   always_comb begin
      code   = code_of(req.char_byte);
      lim    = (copy_limit == 2'd0) ? 8'd1 : {6'd0, copy_limit};
      extend = run_open_ff && (code == held_code_ff) && (run_len_ff < LenWidth'(MAX_RUN));

      push_entry = '0;
      if (extend) begin
         new_code = held_code_ff;
         new_len  = run_len_ff + 8'd1;
      end else begin
         new_code          = code;
         new_len           = 8'd1;
         push_entry.a.vld  = run_open_ff;
         push_entry.a.code = held_code_ff;
         push_entry.a.len  = run_len_ff;
         push_entry.a.esc  = run_len_ff > lim;
      end

      if (req.end_of_string) begin
         push_entry.b.vld  = 1'b1;
         push_entry.b.code = new_code;
         push_entry.b.len  = new_len;
         push_entry.b.esc  = new_len > lim;
         held_code_in      = '0;
         run_len_in        = '0;
         run_open_in       = 1'b0;
      end else begin
         held_code_in = new_code;
         run_len_in   = new_len;
         run_open_in  = 1'b1;
      end

      push = take && (push_entry.a.vld || push_entry.b.vld);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_code_ff <= '0;
         run_len_ff   <= '0;
         run_open_ff  <= 1'b0;
      end else if (take) begin
         held_code_ff <= held_code_in;
         run_len_ff   <= run_len_in;
         run_open_ff  <= run_open_in;
      end
   end

endmodule

[src/ccrle_queue.sv]
// Small job queue between front and back end.
// Depends on ccrle_pkg for the entry and status types.
`timescale 1ns / 1ps

module ccrle_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ccrle_pkg::entry_type    push_entry,
   input  logic                    pop,
   output ccrle_pkg::entry_type    head,
   output ccrle_pkg::q_status_type status
);
   import ccrle_pkg::*;

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CntW'(DEPTH));
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[src/ccrle_back.sv]
// Back end: expands queued flush jobs into result transfers, one per cycle while rsp is ready.
// Depends on ccrle_pkg and ccrle_rsp_if.
`timescale 1ns / 1ps

module ccrle_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ccrle_pkg::entry_type    head,
   input  ccrle_pkg::q_status_type q_status,
   output logic                    pop,
   input  logic [7:0]              marker_value,
   ccrle_rsp_if.source             rsp
);
   import ccrle_pkg::*;

   logic      busy_ff, busy_in;
   entry_type cur_ff, cur_in;
   logic      on_b_ff, on_b_in;
   logic [1:0] step_ff, step_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_value_ff, out_value_in;
   kind_type   out_kind_ff, out_kind_in;
   logic       out_last_ff, out_last_in;

   job_type    job;
   logic [1:0] total;
   logic       job_last;
   logic       entry_last;
   logic       load_out;
   logic       fin;

   always_comb begin
      job        = on_b_ff ? cur_ff.b : cur_ff.a;
      // escaped run: code, marker, count; copied run: len copies (len <= 3)
      total      = job.esc ? 2'd3 : job.len[1:0];
      job_last   = (step_ff == total - 2'd1);
      entry_last = job_last && (on_b_ff || !cur_ff.b.vld);
      load_out   = busy_ff && (!out_valid_ff || rsp.ready);
      fin        = load_out && entry_last;
      pop        = !q_status.empty && (!busy_ff || fin);

      out_value_in = {1'b0, job.code};
      out_kind_in  = KIND_CODE;
      if (job.esc) begin
         case (step_ff)
            2'd1: begin
               out_value_in = marker_value;
               out_kind_in  = KIND_MARKER;
            end
            2'd2: begin
               out_value_in = job.len;
               out_kind_in  = KIND_COUNT;
            end
            default: begin
               out_value_in = {1'b0, job.code};
               out_kind_in  = KIND_CODE;
            end
         endcase
      end
      out_last_in = entry_last;

      busy_in = busy_ff;
      cur_in  = cur_ff;
      on_b_in = on_b_ff;
      step_in = step_ff;
      if (pop) begin
         busy_in = 1'b1;
         cur_in  = head;
         on_b_in = !head.a.vld;
         step_in = 2'd0;
      end else if (fin) begin
         busy_in = 1'b0;
      end else if (load_out) begin
         if (job_last) begin
            on_b_in = 1'b1;
            step_in = 2'd0;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end

      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         on_b_ff      <= 1'b0;
         step_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         on_b_ff      <= on_b_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (load_out) begin
         out_value_ff <= out_value_in;
         out_kind_ff  <= out_kind_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.value         = out_value_ff;
   assign rsp.kind          = out_kind_ff;
   assign rsp.last_of_burst = out_last_ff;

endmodule

[src/ccrle_checker.sv]
// Port-level checker for the encoder, bound to the top level.
// Depends on ccrle_pkg for the kind codes.
`timescale 1ns / 1ps

module ccrle_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_value,
   input logic [1:0] rsp_kind,
   input logic       rsp_last
);
   import ccrle_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_kind)
         && $stable(rsp_last))
      else $error("rsp changed while stalled");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a marker is always followed by its count, never ends a burst
   a_marker_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_MARKER) |-> !rsp_last)
      else $error("marker ends a burst");

   // a count is always last of its job and never smaller than 2
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_COUNT) |-> rsp_value >= 8'd2)
      else $error("escaped run too short");
endmodule

bind char_code_run_length_encoder ccrle_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_value (rsp.value),
   .rsp_kind  (rsp.kind),
   .rsp_last  (rsp.last_of_burst)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for char_code_run_length_encoder: directed and random text,
// predicted code/marker/count results, randomized backpressure and CSR settings.
// Depends on ccrle_pkg, ccrle_if and the encoder RTL.
`timescale 1ns / 1ps

module tb_top;

   import ccrle_pkg::kind_type;
   import ccrle_pkg::KIND_CODE;
   import ccrle_pkg::KIND_MARKER;
   import ccrle_pkg::KIND_COUNT;
   import ccrle_pkg::CSR_MARKER_VALUE;
   import ccrle_pkg::CSR_COPY_LIMIT;

   localparam int RunCap   = 255;   // longest run before a forced flush
   localparam int IdleWait = 8;     // settle cycles after the last result

   typedef struct {
      logic [7:0] ch;
      logic       eos;
   } char_item_type;

   typedef struct {
      logic [7:0] value;
      kind_type   kind;
      logic       last;
   } symbol_type;

   logic clock = 1'b0;
   logic reset;
   logic       csr_wr_en;
   logic       csr_index;
   logic [7:0] csr_wr_data;

   ccrle_req_if req_ch ();
   ccrle_rsp_if rsp_ch ();

   char_code_run_length_encoder #(
      .MAX_RUN (RunCap)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Text waiting to be sent, and the results the encoder owes us
   char_item_type char_stream[$];
   symbol_type    expected_symbols[$];
   char_item_type next_char;
   symbol_type    next_symbol;

   // Shadow of the encoder: CSRs and the open run
   logic [7:0] marker_reg;
   logic [1:0] limit_reg;
   logic [6:0] run_code;
   int         run_len;
   logic       run_active;

   int  send_gap_pct;     // chance in 100 that the sender idles
   int  stall_pct;        // chance in 100 that the receiver stalls
   logic req_taken;       // a req transfer happened at the last rising edge
   int  fail_count;
   int  chars_accepted;
   int  symbols_checked;
   int  csr_writes;

   // Character byte to 7-bit code; bytes outside the table map to 0
   function automatic logic [6:0] char_code(input logic [7:0] ch);
      case (ch)
         8'd33:  return 7'd116;
         8'd34:  return 7'd118;
         8'd35:  return 7'd104;
         8'd36:  return 7'd103;
         8'd37:  return 7'd111;
         8'd38:  return 7'd113;
         8'd39:  return 7'd99;
         8'd48:  return 7'd117;
         8'd64:  return 7'd110;
         8'd65:  return 7'd123;
         8'd80:  return 7'd119;
         8'd100: return 7'd120;
         8'd101: return 7'd2;
         8'd102: return 7'd122;
         8'd103: return 7'd124;
         8'd116: return 7'd121;
         default: ;
      endcase
      if ((ch >= 8'd40 && ch <= 8'd63) || (ch >= 8'd66 && ch <= 8'd90))
         return 7'(ch - 8'd32);
      if ((ch >= 8'd95 && ch <= 8'd99) || (ch >= 8'd104 && ch <= 8'd122))
         return 7'(ch - 8'd36);
      return 7'd0;
   endfunction

   function automatic void push_symbol(input logic [7:0] value, input kind_type kind);
      symbol_type sym;
      sym.value = value;
      sym.kind  = kind;
      sym.last  = 1'b0;
      expected_symbols.insert(expected_symbols.size(), sym);
   endfunction

   // Close the open run: long runs go out as code, marker, count; short ones as copies.
   // A copy limit of zero behaves as one.
   function automatic void close_run();
      int lim;
      lim = (limit_reg == 2'd0) ? 1 : int'(limit_reg);
      if (!run_active)
         return;
      if (run_len > lim) begin
         push_symbol({1'b0, run_code}, KIND_CODE);
         push_symbol(marker_reg, KIND_MARKER);
         push_symbol(8'(run_len), KIND_COUNT);
      end else begin
         for (int j = 0; j < run_len; j++)
            push_symbol({1'b0, run_code}, KIND_CODE);
      end
      run_active = 1'b0;
      run_len    = 0;
   endfunction

   // Predict the results of one accepted character
   function automatic void encode_char(input logic [7:0] ch, input logic eos);
      logic [6:0] code;
      int         first;
      code  = char_code(ch);
      first = expected_symbols.size();
      if (run_active && code == run_code && run_len < RunCap) begin
         run_len++;
      end else begin
         // code change, or a full run that must be flushed
         close_run();
         run_code   = code;
         run_len    = 1;
         run_active = 1'b1;
      end
      if (eos) begin
         close_run();
         run_code = 7'd0;
      end
      if (expected_symbols.size() > first)
         expected_symbols[expected_symbols.size() - 1].last = 1'b1;
   endfunction

   function automatic void queue_char(input logic [7:0] ch, input logic eos);
      char_item_type item;
      item.ch  = ch;
      item.eos = eos;
      char_stream.insert(char_stream.size(), item);
   endfunction

   // A byte outside the code table, so that runs of code 0 mix different bytes
   function automatic logic [7:0] unlisted_byte();
      case ($urandom_range(2))
         0:       return 8'($urandom_range(32));
         1:       return 8'($urandom_range(94, 91));
         default: return 8'($urandom_range(255, 123));
      endcase
   endfunction

   // Mostly well-formed runs of random length and content; the rest is loose noise
   function automatic void queue_random_text(input int n_items);
      int         count;
      int         len;
      logic [7:0] ch;
      logic       zero_run;
      count = 0;
      while (count < n_items) begin
         if ($urandom_range(99) < 15) begin
            queue_char(8'($urandom), $urandom_range(7) == 0);
            count++;
         end else begin
            zero_run = ($urandom_range(3) == 0);
            ch       = 8'($urandom);
            case ($urandom_range(9))
               0:       len = $urandom_range(20, 9);
               1, 2, 3: len = $urandom_range(8, 4);
               default: len = $urandom_range(3, 1);
            endcase
            for (int j = 0; j < len; j++) begin
               // an occasional end of string splits the run
               queue_char(zero_run ? unlisted_byte() : ch,
                          (j == len - 1) ? ($urandom_range(4) == 0)
                                         : ($urandom_range(19) == 0));
            end
            count += len;
         end
      end
   endfunction

   task automatic write_csr(input logic idx, input logic [7:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      if (idx == CSR_MARKER_VALUE)
         marker_reg = data;
      else
         limit_reg = data[1:0];
      csr_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Wait until all text is sent and every owed result has arrived, then let the
   // pipeline settle; bounded so a stuck encoder still reaches the verdict.
   task automatic wait_for_idle();
      int guard;
      guard = 0;
      while ((char_stream.size() != 0 || req_ch.valid || expected_symbols.size() != 0)
             && guard < 50000) begin
         @(negedge clock);
         guard++;
      end
      repeat (IdleWait) @(negedge clock);
   endtask

   // Driver: inputs change on the falling edge. A held item stays put until its
   // transfer; ready is rerolled every cycle.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (char_stream.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            next_char = char_stream.pop_front();
            req_ch.valid         <= 1'b1;
            req_ch.char_byte     <= next_char.ch;
            req_ch.end_of_string <= next_char.eos;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Monitor: sample at the rising edge; predict on each req transfer and check each
   // rsp transfer against the oldest owed result.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            encode_char(req_ch.char_byte, req_ch.end_of_string);
            chars_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_symbols.size() == 0) begin
               $error("unexpected result: value %0d kind %0d last %0d",
                      rsp_ch.value, rsp_ch.kind, rsp_ch.last_of_burst);
               fail_count++;
            end else begin
               next_symbol = expected_symbols.pop_front();
               symbols_checked++;
               if (rsp_ch.value !== next_symbol.value) begin
                  $error("value: expected %0d, got %0d", next_symbol.value, rsp_ch.value);
                  fail_count++;
               end
               if (rsp_ch.kind !== next_symbol.kind) begin
                  $error("kind: expected %0d, got %0d", next_symbol.kind, rsp_ch.kind);
                  fail_count++;
               end
               if (rsp_ch.last_of_burst !== next_symbol.last) begin
                  $error("last_of_burst: expected %0d, got %0d",
                         next_symbol.last, rsp_ch.last_of_burst);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = CSR_MARKER_VALUE;
      csr_wr_data          = 8'd0;
      req_ch.valid         = 1'b0;
      req_ch.char_byte     = 8'd0;
      req_ch.end_of_string = 1'b0;
      rsp_ch.ready         = 1'b0;
      marker_reg           = 8'd126;
      limit_reg            = 2'd3;
      run_code             = 7'd0;
      run_len              = 0;
      run_active           = 1'b0;
      fail_count           = 0;
      chars_accepted       = 0;
      symbols_checked      = 0;
      csr_writes           = 0;
      send_gap_pct         = 11;
      stall_pct            = 49;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed text at reset settings (marker 126, copy limit 3)
      queue_char(8'd0, 1'b0);      // code 0 run from two different unlisted bytes,
      queue_char(8'd255, 1'b1);    // closed by end of string: two copies
      queue_char("A", 1'b0);
      queue_char("e", 1'b0);       // code change flushes the single A
      queue_char("e", 1'b0);
      queue_char("e", 1'b0);
      queue_char("e", 1'b0);
      queue_char("!", 1'b0);       // run of 4 > limit: code, marker, count
      queue_char("!", 1'b1);
      queue_char("g", 1'b1);       // one-character string
      queue_char("x", 1'b0);
      queue_char("x", 1'b0);
      queue_char("x", 1'b0);
      queue_char("@", 1'b1);       // four results from one transfer
      queue_char("0", 1'b0);
      queue_char("0", 1'b0);
      queue_char("0", 1'b0);
      queue_char("0", 1'b1);       // escaped flush on end of string
      queue_char("P", 1'b0);
      queue_char("P", 1'b0);
      queue_char("z", 1'b0);
      queue_char("t", 1'b0);
      queue_char("d", 1'b0);
      queue_char("f", 1'b0);
      queue_char(8'd127, 1'b1);
      wait_for_idle();

      // Lowest marker, copy limit 1
      write_csr(CSR_MARKER_VALUE, 8'd0);
      write_csr(CSR_COPY_LIMIT, {6'($urandom), 2'd1});
      queue_random_text(30);
      wait_for_idle();

      // Receiver mostly ready, sender gappy; highest marker, copy limit 0 (acts as 1)
      send_gap_pct = 49;
      stall_pct    = 11;
      write_csr(CSR_MARKER_VALUE, 8'd255);
      write_csr(CSR_COPY_LIMIT, {6'($urandom), 2'd0});
      queue_random_text(30);
      wait_for_idle();

      // Full rate; a run past the cap forces a flush with count 255
      send_gap_pct = 0;
      stall_pct    = 0;
      write_csr(CSR_MARKER_VALUE, 8'($urandom));
      write_csr(CSR_COPY_LIMIT, {6'($urandom), 2'd2});
      queue_random_text(10);
      for (int j = 0; j < RunCap + 3; j++)
         queue_char("k", j == RunCap + 2);
      queue_random_text(10);
      wait_for_idle();

      write_csr(CSR_MARKER_VALUE, 8'($urandom));
      write_csr(CSR_COPY_LIMIT, {6'($urandom), 2'd3});
      queue_random_text(15);
      wait_for_idle();

      if (expected_symbols.size() != 0) begin
         $error("%0d results never arrived", expected_symbols.size());
         fail_count++;
      end
      $display("Sent %0d characters over 5 phases with %0d CSR writes; checked %0d results.",
               chars_accepted, csr_writes, symbols_checked);
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule

[filelist.f]
src/ccrle_pkg.sv
src/ccrle_if.sv
src/ccrle_front.sv
src/ccrle_queue.sv
src/ccrle_back.sv
src/char_code_run_length_encoder.sv
src/ccrle_checker.sv
tb/sv/tb_top.sv
